// File: src/dls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dls_pkg
// Shared constants, types and helpers of the two-axis line step generator.
// ----------------------------------------------------------------------------
package dls_pkg;

	localparam int POS_BITS = 24;
	localparam int OUT_W    = 24;
	localparam int DELTA_W  = 24;
	localparam int SPAN_W   = 23;
	localparam int ACC_W    = 25;
	localparam int CMP_W    = 33;

	localparam logic [SPAN_W-1:0] X_LIMIT_RESET = SPAN_W'(24150);
	localparam logic [SPAN_W-1:0] SPAN_MAX      = {SPAN_W{1'b1}};

	typedef enum logic [1:0] {
		MODE_LOAD   = 2'd0,
		MODE_TICK   = 2'd1,
		MODE_ZERO   = 2'd2,
		MODE_CANCEL = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [SPAN_W-1:0]  x_span;
		logic [SPAN_W-1:0]  y_span;
		logic               x_up;
		logic               y_up;
		logic               y_major;
	} cmd_t;

	typedef struct packed {
		logic [OUT_W-1:0] x_pos;
		logic [OUT_W-1:0] y_pos;
		logic             x_stepped;
		logic             y_stepped;
		logic             busy;
		logic             soft_stop;
	} res_t;

	// Magnitude of a signed delta, saturated to the span width.
	function automatic logic [SPAN_W-1:0] span_of(input logic [DELTA_W-1:0] v);
		logic [DELTA_W-1:0] mag;
		mag = v[DELTA_W-1] ? (~v + DELTA_W'(1)) : v;
		if (mag[DELTA_W-1]) begin
			return SPAN_MAX;
		end
		return mag[SPAN_W-1:0];
	endfunction

endpackage

// File: src/dls_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dls_front
// Accepts input beats, decodes the mode and derives spans, directions and
// the major axis of a load, holding the result in one pipeline register.
// ----------------------------------------------------------------------------
module dls_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [1:0]                  mode,
	input  logic [dls_pkg::DELTA_W-1:0] delta_x,
	input  logic [dls_pkg::DELTA_W-1:0] delta_y,
	output logic                        cmd_valid,
	input  logic                        cmd_ready,
	output dls_pkg::cmd_t               cmd
);
	import dls_pkg::*;

	logic              valid_s1;
	cmd_t              cmd_s1;
	cmd_t              cmd_d;
	logic [SPAN_W-1:0] xs;
	logic [SPAN_W-1:0] ys;
	logic              take;

	assign full      = valid_s1 & ~cmd_ready;
	assign take      = push & ~full;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_comb begin
		xs             = span_of(delta_x);
		ys             = span_of(delta_y);
		cmd_d.mode     = mode_t'(mode);
		cmd_d.x_span   = xs;
		cmd_d.y_span   = ys;
		cmd_d.x_up     = ~delta_x[DELTA_W-1] & (delta_x != '0);
		cmd_d.y_up     = ~delta_y[DELTA_W-1] & (delta_y != '0);
		cmd_d.y_major  = ~(xs > ys);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

// File: src/dls_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dls_cmd_queue
// Two-entry queue of decoded commands between the front and the back end.
// ----------------------------------------------------------------------------
module dls_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  dls_pkg::cmd_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output dls_pkg::cmd_t rd_data
);
	import dls_pkg::*;

	cmd_t       mem_q [2];
	logic [1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       do_wr;
	logic       do_rd;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid & wr_ready;
	assign do_rd    = rd_valid & rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_wr & ~do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd & ~do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: src/dls_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dls_back
// Holds the move state and limit register; carries out one command per cycle
// while its two-entry output queue has room and places each result beat there.
// ----------------------------------------------------------------------------
module dls_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  dls_pkg::cmd_t              cmd,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [dls_pkg::SPAN_W-1:0] cfg_data,
	output logic                       empty,
	input  logic                       pop,
	output dls_pkg::res_t              res
);
	import dls_pkg::*;

	logic [SPAN_W-1:0]   x_limit_q;
	logic [POS_BITS-1:0] x_position_q;
	logic [POS_BITS-1:0] y_position_q;
	logic [SPAN_W-1:0]   x_span_q;
	logic [SPAN_W-1:0]   y_span_q;
	logic                x_dir_up_q;
	logic                y_dir_up_q;
	logic                y_major_q;
	logic [SPAN_W-1:0]   steps_left_q;
	logic [ACC_W-1:0]    error_acc_q;
	logic                stopped_q;

	res_t       res_mem_q [2];
	logic [1:0] res_cnt_q;
	logic       res_wr_q;
	logic       res_rd_q;

	logic                take;
	logic                do_pop;
	logic [SPAN_W-1:0]   major;
	logic [SPAN_W-1:0]   minor;
	logic [ACC_W-1:0]    acc_sum;
	logic                minor_step;
	logic                active;
	logic                xs;
	logic                ys;
	logic [POS_BITS-1:0] x_next;
	logic [POS_BITS-1:0] y_next;
	logic                x_out;
	logic [SPAN_W-1:0]   ld_steps;

	logic [POS_BITS-1:0] x_pos_d;
	logic [POS_BITS-1:0] y_pos_d;
	logic [SPAN_W-1:0]   x_span_d;
	logic [SPAN_W-1:0]   y_span_d;
	logic                x_dir_d;
	logic                y_dir_d;
	logic                y_major_d;
	logic [SPAN_W-1:0]   steps_d;
	logic [ACC_W-1:0]    acc_d;
	logic                stopped_d;
	res_t                res_d;

	assign cfg_ready = 1'b1;
	assign cmd_ready = (res_cnt_q != 2'd2);
	assign take      = cmd_valid & cmd_ready;
	assign empty     = (res_cnt_q == 2'd0);
	assign do_pop    = pop & ~empty;
	assign res       = res_mem_q[res_rd_q];

	always_comb begin
		major      = y_major_q ? y_span_q : x_span_q;
		minor      = y_major_q ? x_span_q : y_span_q;
		acc_sum    = error_acc_q + ACC_W'(minor);
		minor_step = (acc_sum >= ACC_W'(major));
		active     = (steps_left_q != '0) & ~stopped_q;
		xs         = active & (y_major_q ? minor_step : 1'b1);
		ys         = active & (y_major_q ? 1'b1 : minor_step);
		x_next     = xs ? (x_dir_up_q ? x_position_q + POS_BITS'(1)
		                              : x_position_q - POS_BITS'(1)) : x_position_q;
		y_next     = ys ? (y_dir_up_q ? y_position_q + POS_BITS'(1)
		                              : y_position_q - POS_BITS'(1)) : y_position_q;
		x_out      = x_next[POS_BITS-1] | (CMP_W'(x_next) > CMP_W'(x_limit_q));
		ld_steps   = cmd.y_major ? cmd.y_span : cmd.x_span;

		x_pos_d   = x_position_q;
		y_pos_d   = y_position_q;
		x_span_d  = x_span_q;
		y_span_d  = y_span_q;
		x_dir_d   = x_dir_up_q;
		y_dir_d   = y_dir_up_q;
		y_major_d = y_major_q;
		steps_d   = steps_left_q;
		acc_d     = error_acc_q;
		stopped_d = stopped_q;
		res_d.x_stepped = 1'b0;
		res_d.y_stepped = 1'b0;

		case (cmd.mode)
			MODE_LOAD: begin
				x_span_d  = cmd.x_span;
				y_span_d  = cmd.y_span;
				x_dir_d   = cmd.x_up;
				y_dir_d   = cmd.y_up;
				y_major_d = cmd.y_major;
				steps_d   = ld_steps;
				acc_d     = ACC_W'(ld_steps >> 1);
				stopped_d = 1'b0;
			end
			MODE_TICK: begin
				if (active) begin
					steps_d = steps_left_q - SPAN_W'(1);
					acc_d   = minor_step ? acc_sum - ACC_W'(major) : acc_sum;
					x_pos_d = x_next;
					y_pos_d = y_next;
					res_d.x_stepped = xs;
					res_d.y_stepped = ys;
					if (x_out) begin
						stopped_d = 1'b1;
						steps_d   = '0;
					end
				end
			end
			MODE_ZERO: begin
				x_pos_d = '0;
				y_pos_d = '0;
			end
			MODE_CANCEL: begin
				steps_d = '0;
			end
			default: begin
				steps_d = steps_left_q;
			end
		endcase

		res_d.x_pos     = OUT_W'(x_pos_d);
		res_d.y_pos     = OUT_W'(y_pos_d);
		res_d.busy      = (steps_d != '0);
		res_d.soft_stop = stopped_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_limit_q    <= X_LIMIT_RESET;
			x_position_q <= '0;
			y_position_q <= '0;
			x_span_q     <= '0;
			y_span_q     <= '0;
			x_dir_up_q   <= 1'b1;
			y_dir_up_q   <= 1'b0;
			y_major_q    <= 1'b0;
			steps_left_q <= '0;
			error_acc_q  <= '0;
			stopped_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				x_limit_q <= cfg_data;
			end
			if (take) begin
				x_position_q <= x_pos_d;
				y_position_q <= y_pos_d;
				x_span_q     <= x_span_d;
				y_span_q     <= y_span_d;
				x_dir_up_q   <= x_dir_d;
				y_dir_up_q   <= y_dir_d;
				y_major_q    <= y_major_d;
				steps_left_q <= steps_d;
				error_acc_q  <= acc_d;
				stopped_q    <= stopped_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= 2'd0;
			res_wr_q  <= 1'b0;
			res_rd_q  <= 1'b0;
		end else begin
			if (take) begin
				res_wr_q <= ~res_wr_q;
			end
			if (do_pop) begin
				res_rd_q <= ~res_rd_q;
			end
			if (take & ~do_pop) begin
				res_cnt_q <= res_cnt_q + 2'd1;
			end else if (do_pop & ~take) begin
				res_cnt_q <= res_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_mem_q[res_wr_q] <= res_d;
		end
	end

endmodule

// File: src/dls_line_stepper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_line_stepper
// Two-axis line step generator with a decoupled decode front end and an
// execution back end joined by a two-entry command queue.
// ----------------------------------------------------------------------------
//  Channel   Handshake        Payload
//  input     push / full      mode, delta_x, delta_y
//  result    empty / pop      x_pos, y_pos, x_stepped, y_stepped, busy_res,
//                             soft_stop
//  config    cfg_valid/ready  cfg_data (x_limit)
//
// One item per clock is sustained while results are popped; a result is on the
// result ports once its input beat has passed the decode register (written at
// the accepting edge), then the command queue, then the result queue.
// The back end's combinational add, compare and position update sets the rate.
// Reset restores the limit to its default and resets all move state (X direction up, all else zero).
// A stalled result side fills the result queue, then the command queue, and
// then raises full; config beats are always taken.
// ----------------------------------------------------------------------------
module dda_line_stepper (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [1:0]                  mode,
	input  logic [dls_pkg::DELTA_W-1:0] delta_x,
	input  logic [dls_pkg::DELTA_W-1:0] delta_y,
	output logic                        empty,
	input  logic                        pop,
	output logic [dls_pkg::OUT_W-1:0]   x_pos,
	output logic [dls_pkg::OUT_W-1:0]   y_pos,
	output logic                        x_stepped,
	output logic                        y_stepped,
	output logic                        busy_res,
	output logic                        soft_stop,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [dls_pkg::SPAN_W-1:0]  cfg_data
);
	import dls_pkg::*;

	logic f_valid;
	logic f_ready;
	cmd_t f_cmd;
	logic b_valid;
	logic b_ready;
	cmd_t b_cmd;
	res_t res;

	dls_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.delta_x   (delta_x),
		.delta_y   (delta_y),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	dls_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_cmd),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_cmd)
	);

	dls_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd       (b_cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign x_pos     = res.x_pos;
	assign y_pos     = res.y_pos;
	assign x_stepped = res.x_stepped;
	assign y_stepped = res.y_stepped;
	assign busy_res  = res.busy;
	assign soft_stop = res.soft_stop;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-axis line step generator. A queue of
// commands (loads, step ticks, position clears, cancels) feeds a clocked
// driver. A software copy of the stepper predicts each position report when
// its command beat is accepted. A clocked monitor compares every report beat
// with the oldest prediction. The phases change the X limit and the amount of
// idling on the command and report sides.
// ----------------------------------------------------------------------------
module tb;

	import dls_pkg::*;

	typedef struct {
		mode_t              op;
		logic [DELTA_W-1:0] dx;
		logic [DELTA_W-1:0] dy;
	} cmd_item_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic                full;
	logic [1:0]          mode = MODE_TICK;
	logic [DELTA_W-1:0]  delta_x = '0;
	logic [DELTA_W-1:0]  delta_y = '0;
	logic                empty;
	logic                pop = 1'b0;
	logic [OUT_W-1:0]    x_pos;
	logic [OUT_W-1:0]    y_pos;
	logic                x_stepped;
	logic                y_stepped;
	logic                busy_res;
	logic                soft_stop;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [SPAN_W-1:0]   cfg_data = '0;

	cmd_item_t cmd_q[$];
	res_t      report_q[$];
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        mismatches = 0;
	int        cmds_queued = 0;

	// Software copy of the stepper state.
	logic [SPAN_W-1:0]   m_limit = X_LIMIT_RESET;
	logic [POS_BITS-1:0] m_x = '0;
	logic [POS_BITS-1:0] m_y = '0;
	logic [SPAN_W-1:0]   m_x_span = '0;
	logic [SPAN_W-1:0]   m_y_span = '0;
	logic                m_x_up = 1'b1;
	logic                m_y_up = 1'b0;
	logic                m_y_major = 1'b0;
	logic [SPAN_W-1:0]   m_steps = '0;
	logic [ACC_W-1:0]    m_acc = '0;
	logic                m_stopped = 1'b0;

	dda_line_stepper i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.delta_x   (delta_x),
		.delta_y   (delta_y),
		.empty     (empty),
		.pop       (pop),
		.x_pos     (x_pos),
		.y_pos     (y_pos),
		.x_stepped (x_stepped),
		.y_stepped (y_stepped),
		.busy_res  (busy_res),
		.soft_stop (soft_stop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [SPAN_W-1:0] delta_span(input logic [DELTA_W-1:0] d);
		int v;
		v = int'($signed(d));
		if (v < 0) begin
			v = -v;
		end
		if (v > int'(SPAN_MAX)) begin
			v = int'(SPAN_MAX);
		end
		return v[SPAN_W-1:0];
	endfunction

	function automatic void advance_axes(input cmd_item_t c);
		res_t              r;
		logic [SPAN_W-1:0] major;
		logic [SPAN_W-1:0] minor;
		logic              xs;
		logic              ys;
		xs = 1'b0;
		ys = 1'b0;
		case (c.op)
			MODE_LOAD: begin
				m_x_span  = delta_span(c.dx);
				m_y_span  = delta_span(c.dy);
				m_x_up    = $signed(c.dx) > 0;
				m_y_up    = $signed(c.dy) > 0;
				m_y_major = !(m_x_span > m_y_span);
				m_steps   = m_y_major ? m_y_span : m_x_span;
				m_acc     = ACC_W'(m_steps >> 1);
				m_stopped = 1'b0;
			end
			MODE_TICK: begin
				if (m_steps != 0 && !m_stopped) begin
					major   = m_y_major ? m_y_span : m_x_span;
					minor   = m_y_major ? m_x_span : m_y_span;
					m_steps = m_steps - 1'b1;
					if (m_y_major) begin
						ys = 1'b1;
					end else begin
						xs = 1'b1;
					end
					m_acc = m_acc + ACC_W'(minor);
					if (m_acc >= ACC_W'(major)) begin
						m_acc = m_acc - ACC_W'(major);
						if (m_y_major) begin
							xs = 1'b1;
						end else begin
							ys = 1'b1;
						end
					end
					if (xs) begin
						m_x = m_x_up ? m_x + 1'b1 : m_x - 1'b1;
					end
					if (ys) begin
						m_y = m_y_up ? m_y + 1'b1 : m_y - 1'b1;
					end
					if (m_x[POS_BITS-1] || m_x > POS_BITS'(m_limit)) begin
						m_stopped = 1'b1;
						m_steps   = '0;
					end
				end
			end
			MODE_ZERO: begin
				m_x = '0;
				m_y = '0;
			end
			default: begin
				m_steps = '0;
			end
		endcase
		r.x_pos     = m_x[OUT_W-1:0];
		r.y_pos     = m_y[OUT_W-1:0];
		r.x_stepped = xs;
		r.y_stepped = ys;
		r.busy      = m_steps != 0;
		r.soft_stop = m_stopped;
		report_q.push_back(r);
	endfunction

	function automatic string fmt_report(input res_t r);
		return $sformatf("x=%0d y=%0d xs=%b ys=%b busy=%b stop=%b", $signed(r.x_pos),
			$signed(r.y_pos), r.x_stepped, r.y_stepped, r.busy, r.soft_stop);
	endfunction

	// Driver: one command beat per accepted push.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				advance_axes(cmd_q.pop_front());
			end
			if (!(push && full)) begin
				if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					push    <= 1'b1;
					mode    <= cmd_q[0].op;
					delta_x <= cmd_q[0].dx;
					delta_y <= cmd_q[0].dy;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares every report beat with the oldest prediction.
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				got.x_pos     = x_pos;
				got.y_pos     = y_pos;
				got.x_stepped = x_stepped;
				got.y_stepped = y_stepped;
				got.busy      = busy_res;
				got.soft_stop = soft_stop;
				if (report_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected report beat: %s", fmt_report(got));
					end
				end else begin
					want = report_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("report mismatch: expected %s, actual %s",
								fmt_report(want), fmt_report(got));
						end
					end
				end
			end
			pop <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	task automatic add_cmd(input mode_t op, input logic [DELTA_W-1:0] dx,
			input logic [DELTA_W-1:0] dy);
		cmd_item_t c;
		c.op = op;
		c.dx = dx;
		c.dy = dy;
		cmd_q.push_back(c);
		cmds_queued++;
	endtask

	task automatic wait_drained();
		while (cmd_q.size() != 0 || report_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(input logic [SPAN_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		m_limit = v;
	endtask

	task automatic add_moves(input int n);
		int start;
		int kind;
		int sx;
		int sy;
		int ticks;
		int r;
		start = cmds_queued;
		while (cmds_queued - start < n) begin
			kind = $urandom_range(99);
			if (kind < 72) begin
				sx = int'($urandom_range(120)) - 60;
				sy = int'($urandom_range(120)) - 60;
				if ($urandom_range(9) == 0) begin
					sy = $urandom_range(1) ? sx : -sx;
				end
				if ($urandom_range(9) == 0) begin
					sx = 0;
				end
				add_cmd(MODE_LOAD, DELTA_W'(sx), DELTA_W'(sy));
				ticks = (sx < 0 ? -sx : sx) > (sy < 0 ? -sy : sy) ?
					(sx < 0 ? -sx : sx) : (sy < 0 ? -sy : sy);
				ticks = ticks + int'($urandom_range(3));
				for (int k = 0; k < ticks; k++) begin
					r = $urandom_range(199);
					if (r < 3) begin
						add_cmd(MODE_ZERO, DELTA_W'($urandom), DELTA_W'($urandom));
					end else if (r < 5) begin
						add_cmd(MODE_CANCEL, DELTA_W'($urandom), DELTA_W'($urandom));
					end
					add_cmd(MODE_TICK, DELTA_W'($urandom), DELTA_W'($urandom));
				end
			end else if (kind < 87) begin
				add_cmd(MODE_LOAD, DELTA_W'($urandom), DELTA_W'($urandom));
				repeat ($urandom_range(1, 6)) begin
					add_cmd(MODE_TICK, '0, '0);
				end
			end else begin
				add_cmd(mode_t'($urandom_range(3)), DELTA_W'($urandom), DELTA_W'($urandom));
			end
		end
	endtask

	task automatic run_phase(input int send_idle, input int recv_stall,
			input logic [SPAN_W-1:0] limit, input int n);
		send_idle_pct  = send_idle;
		recv_stall_pct = recv_stall;
		write_limit(limit);
		add_moves(n / 2);
		wait_drained();
		add_moves(n - n / 2);
		wait_drained();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_cmd(MODE_TICK, '0, '0);
		add_cmd(MODE_LOAD, '0, '0);
		add_cmd(MODE_TICK, '0, '0);
		add_cmd(MODE_LOAD, 24'h800000, 24'h7FFFFF);
		add_cmd(MODE_TICK, '0, '0);
		add_cmd(MODE_TICK, '0, '0);
		add_cmd(MODE_CANCEL, '0, '0);
		add_cmd(MODE_LOAD, 24'h7FFFFF, 24'h800000);
		add_cmd(MODE_TICK, '0, '0);
		add_cmd(MODE_CANCEL, 24'hFFFFFF, 24'hFFFFFF);
		add_cmd(MODE_TICK, '0, '0);
		add_cmd(MODE_ZERO, '0, '0);
		add_cmd(MODE_LOAD, DELTA_W'(5), DELTA_W'(2));
		repeat (6) add_cmd(MODE_TICK, '0, '0);
		add_cmd(MODE_LOAD, DELTA_W'(3), DELTA_W'(-7));
		repeat (3) add_cmd(MODE_TICK, '0, '0);
		add_cmd(MODE_ZERO, '0, '0);
		add_cmd(MODE_TICK, '0, '0);
		add_cmd(MODE_LOAD, DELTA_W'(-1), '0);
		add_cmd(MODE_TICK, '0, '0);
		add_cmd(MODE_CANCEL, '0, '0);
		wait_drained();

		run_phase(0, 0, SPAN_MAX, 360);
		run_phase(52, 0, '0, 340);
		run_phase(0, 52, SPAN_W'(300), 340);
		run_phase(27, 27, SPAN_W'($urandom_range(1000, 40000)), 340);

		if (mismatches == 0) begin
			$display("[dda_line_stepper] OK");
		end else begin
			$display("[dda_line_stepper] ERROR");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[dda_line_stepper] ERROR");
		$finish;
	end

endmodule

// File: files.f
src/dls_pkg.sv
src/dls_front.sv
src/dls_cmd_queue.sv
src/dls_back.sv
src/dls_line_stepper_top.sv
tb/tb.sv
